>>> rtl/point_to_line_distance_normal_top_macros.svh
// Assertion helpers for the checker file.
`ifndef POINT_TO_LINE_DISTANCE_NORMAL_TOP_MACROS_SVH
`define POINT_TO_LINE_DISTANCE_NORMAL_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define PTLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define PTLD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/ptld_pkg.sv
`timescale 1ns / 1ps

package ptld_pkg;

    localparam int CW      = 32;
    localparam int DW      = CW + 1;
    localparam int PW      = 2 * DW;
    localparam int CMW     = 2 * CW + 1;
    localparam int CLW     = DW;
    localparam int CHW     = CMW - CLW;
    localparam int DMW     = CW;
    localparam int DDW     = 2 * CW + 2;
    localparam int SQW     = 2 * CMW;
    localparam int CCW     = SQW + 2;
    localparam int NPW     = CHW + DMW + CLW;
    localparam int NW      = NPW + 2;
    localparam int NMW     = NPW + 1;

    localparam int SQ_W    = 64;
    localparam int RT_W    = SQ_W / 2;
    localparam int QW      = SQ_W;
    localparam int DIST_W  = RT_W;

    localparam int MW         = 31;
    localparam int NORM_STEPS = 7;
    localparam int ONE_SH     = 16;
    localparam int NQW        = ONE_SH + 1;
    localparam int NUMW       = MW + ONE_SH + 1;
    localparam int NOUT_W     = NQW + 1;

    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 3;

    // Pipeline timing, in register stages counted from the input register.
    localparam int ST_PREP    = 8;
    localparam int DDIV       = QW;
    localparam int ST_NSQ     = ST_PREP + NORM_STEPS + 1;
    localparam int ST_NPREP   = ST_NSQ + 2 + RT_W;
    localparam int ST_NSIGN   = ST_NPREP + NQW + 1;
    localparam int ST_DROOT   = ST_PREP + DDIV + RT_W;
    localparam int LAT        = ST_DROOT + 2;
    localparam int SD_W       = ST_W + 1;
    localparam int SD_DLY     = ST_DROOT - ST_PREP + 1;
    localparam int MN_DLY     = ST_NPREP - ST_NSQ;
    localparam int NRM_DLY    = ST_DROOT - ST_NSIGN + 1;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_LINE = 2'd1,
        ST_ON_LINE   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_END_X   = 3'd3,
        CFG_END_Y   = 3'd4,
        CFG_END_Z   = 3'd5
    } cfg_idx_t;

endpackage

>>> rtl/ptld_isqrt.sv
`timescale 1ns / 1ps

module ptld_isqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [ptld_pkg::SQ_W-1:0]  x_in,
    output logic [ptld_pkg::RT_W-1:0]  root_out
);
    import ptld_pkg::*;

    logic [SQ_W-1:0] x_reg  [RT_W];
    logic [RT_W-1:0] r_reg  [RT_W];
    logic [SQ_W-1:0] r2_reg [RT_W];

    // One root bit per stage, most significant first; r2 tracks the square of the root.
    for (genvar i = 0; i < RT_W; i++) begin : g_stage
        localparam int B = RT_W - 1 - i;
        logic [SQ_W-1:0] x_prv;
        logic [RT_W-1:0] r_prv;
        logic [SQ_W-1:0] r2_prv;
        logic [SQ_W:0]   t2;
        logic            take;

        if (i == 0) begin : g_first
            assign x_prv  = x_in;
            assign r_prv  = '0;
            assign r2_prv = '0;
        end else begin : g_next
            assign x_prv  = x_reg[i-1];
            assign r_prv  = r_reg[i-1];
            assign r2_prv = r2_reg[i-1];
        end

        assign t2   = {1'b0, r2_prv} + ((SQ_W+1)'(r_prv) << (B + 1))
                    + ((SQ_W+1)'(1) << (2 * B));
        assign take = t2 <= {1'b0, x_prv};

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i]  <= x_prv;
                r_reg[i]  <= take ? (r_prv | (RT_W'(1) << B)) : r_prv;
                r2_reg[i] <= take ? t2[SQ_W-1:0] : r2_prv;
            end
        end
    end

    assign root_out = r_reg[RT_W-1];

endmodule

>>> rtl/point_to_line_distance_normal_top.sv
// Perpendicular distance and unit normal from a query point to a configured 3D line.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// The depth is set by the 64-stage quotient divider and the 32-stage square root.
// Reset clears the valid pipeline and sets every line register to zero.
`timescale 1ns / 1ps

module point_to_line_distance_normal_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ptld_pkg::CW-1:0]        s_query_x,
    input  logic signed [ptld_pkg::CW-1:0]        s_query_y,
    input  logic signed [ptld_pkg::CW-1:0]        s_query_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ptld_pkg::DIST_W-1:0]           m_distance,
    output logic signed [ptld_pkg::NOUT_W-1:0]    m_normal_x,
    output logic signed [ptld_pkg::NOUT_W-1:0]    m_normal_y,
    output logic signed [ptld_pkg::NOUT_W-1:0]    m_normal_z,
    output logic [ptld_pkg::ST_W-1:0]             m_status,
    input  logic                                  cfg_wen,
    input  logic [ptld_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ptld_pkg::CW-1:0]               cfg_wdata
);
    import ptld_pkg::*;

    logic en;
    logic vld_reg [LAT];

    logic signed [CW-1:0]  start_reg [3];
    logic signed [CW-1:0]  end_reg   [3];
    logic signed [CW-1:0]  q_reg     [3];
    logic signed [DW-1:0]  d1_reg    [3];
    logic signed [DW-1:0]  v1_reg    [3];
    logic signed [DW-1:0]  d2_reg    [3];
    logic signed [DW-1:0]  d3_reg    [3];
    logic signed [PW-1:0]  pa_reg    [3];
    logic signed [PW-1:0]  pb_reg    [3];
    logic [PW-1:0]         dsq_reg   [3];
    logic signed [PW-1:0]  c_reg     [3];
    logic [DDW-1:0]        dd3_reg, dd4_reg, dd5_reg, dd6_reg, dd7_reg;
    logic [CMW-1:0]        cm_reg    [3];
    logic [DMW-1:0]        dm_reg    [3];
    logic [2:0]            cs_reg, ds_reg;
    status_t               st4_reg, st5_reg, st6_reg, st7_reg;
    logic [CHW-1:0]        ch        [3];
    logic [CLW-1:0]        cl        [3];
    logic [2*CHW-1:0]      hh_reg    [3];
    logic [CHW+CLW-1:0]    hl_reg    [3];
    logic [2*CLW-1:0]      ll_reg    [3];
    logic [CHW+DMW-1:0]    ah_reg    [3];
    logic [CHW+DMW-1:0]    bh_reg    [3];
    logic [CLW+DMW-1:0]    al_reg    [3];
    logic [CLW+DMW-1:0]    bl_reg    [3];
    logic [2:0]            asg_reg, bsg_reg;
    logic [SQW-1:0]        sq_reg    [3];
    logic signed [NPW:0]   ta_reg    [3];
    logic signed [NPW:0]   tb_reg    [3];
    logic [CCW-1:0]        cc_reg;
    logic signed [NW-1:0]  n_reg     [3];

    logic [CCW-QW-1:0]     cc_hi;
    logic                  ovf;
    logic [SD_W-1:0]       sd_dly_reg [SD_DLY];
    logic [DDW-1:0]        dv_pr_reg  [DDIV+1];
    logic [QW-1:0]         dv_lo_reg  [DDIV+1];
    logic [DDW-1:0]        dv_dd_reg  [DDIV+1];
    logic [RT_W-1:0]       d_root;

    logic [NMW-1:0]        nz_reg     [NORM_STEPS+1][3];
    logic [2:0]            nz_neg_reg [NORM_STEPS+1];
    logic [2*MW-1:0]       msq_reg    [3];
    logic [SQ_W-1:0]       msum_reg;
    logic [MW-1:0]         m_dly_reg  [MN_DLY][3];
    logic [2:0]            neg_dly_reg [MN_DLY];
    logic [RT_W-1:0]       n_len;
    logic [RT_W-1:0]       len_v;
    logic [RT_W-1:0]       nd_pr_reg  [NQW+1][3];
    logic [NQW-1:0]        nd_lo_reg  [NQW+1][3];
    logic [RT_W-1:0]       nd_len_reg [NQW+1];
    logic [2:0]            nd_neg_reg [NQW+1];
    logic signed [NOUT_W-1:0] nrm_dly_reg [NRM_DLY][3];

    logic [DIST_W-1:0]        dist_reg;
    logic signed [NOUT_W-1:0] nx_reg, ny_reg, nz_out_reg;
    status_t                  status_reg;
    status_t                  fin_status;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                start_reg[k] <= '0;
                end_reg[k]   <= '0;
            end
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_START_X: start_reg[0] <= cfg_wdata;
                CFG_START_Y: start_reg[1] <= cfg_wdata;
                CFG_START_Z: start_reg[2] <= cfg_wdata;
                CFG_END_X:   end_reg[0]   <= cfg_wdata;
                CFG_END_Y:   end_reg[1]   <= cfg_wdata;
                CFG_END_Z:   end_reg[2]   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0] <= s_query_x;
            q_reg[1] <= s_query_y;
            q_reg[2] <= s_query_z;
        end
    end

    // Direction, offset, cross product, squared lengths and the normal vector.
    for (genvar i = 0; i < 3; i++) begin : g_lane
        localparam int A = (i + 1) % 3;
        localparam int B = (i + 2) % 3;
        logic signed [PW-1:0] cneg;
        logic signed [DW-1:0] dneg;
        logic [NPW-1:0]       am, bm;
        logic signed [NW-1:0] nneg;

        assign cneg = -c_reg[i];
        assign dneg = -d3_reg[i];
        assign ch[i] = cm_reg[i][CMW-1:CLW];
        assign cl[i] = cm_reg[i][CLW-1:0];
        assign am   = (NPW'(ah_reg[i]) << CLW) + NPW'(al_reg[i]);
        assign bm   = (NPW'(bh_reg[i]) << CLW) + NPW'(bl_reg[i]);
        assign nneg = -n_reg[i];

        always_ff @(posedge aclk) begin
            if (en) begin
                d1_reg[i]  <= {end_reg[i][CW-1], end_reg[i]} - {start_reg[i][CW-1], start_reg[i]};
                v1_reg[i]  <= {q_reg[i][CW-1], q_reg[i]} - {start_reg[i][CW-1], start_reg[i]};

                pa_reg[i]  <= d1_reg[A] * v1_reg[B];
                pb_reg[i]  <= d1_reg[B] * v1_reg[A];
                dsq_reg[i] <= d1_reg[i] * d1_reg[i];
                d2_reg[i]  <= d1_reg[i];

                c_reg[i]   <= pa_reg[i] - pb_reg[i];
                d3_reg[i]  <= d2_reg[i];

                cs_reg[i]  <= c_reg[i][PW-1];
                cm_reg[i]  <= c_reg[i][PW-1] ? cneg[CMW-1:0] : c_reg[i][CMW-1:0];
                ds_reg[i]  <= d3_reg[i][DW-1];
                dm_reg[i]  <= d3_reg[i][DW-1] ? dneg[DMW-1:0] : d3_reg[i][DMW-1:0];

                hh_reg[i]  <= ch[i] * ch[i];
                hl_reg[i]  <= ch[i] * cl[i];
                ll_reg[i]  <= cl[i] * cl[i];
                ah_reg[i]  <= ch[A] * dm_reg[B];
                al_reg[i]  <= cl[A] * dm_reg[B];
                asg_reg[i] <= cs_reg[A] ^ ds_reg[B];
                bh_reg[i]  <= ch[B] * dm_reg[A];
                bl_reg[i]  <= cl[B] * dm_reg[A];
                bsg_reg[i] <= cs_reg[B] ^ ds_reg[A];

                sq_reg[i]  <= (SQW'(hh_reg[i]) << (2 * CLW)) + (SQW'(hl_reg[i]) << (CLW + 1))
                            + SQW'(ll_reg[i]);
                ta_reg[i]  <= asg_reg[i] ? -$signed({1'b0, am}) : $signed({1'b0, am});
                tb_reg[i]  <= bsg_reg[i] ? -$signed({1'b0, bm}) : $signed({1'b0, bm});

                n_reg[i]   <= NW'(ta_reg[i]) - NW'(tb_reg[i]);

                nz_reg[0][i]  <= n_reg[i][NW-1] ? nneg[NMW-1:0] : n_reg[i][NMW-1:0];
                nz_neg_reg[0][i] <= n_reg[i][NW-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dd3_reg <= DDW'(dsq_reg[0]) + DDW'(dsq_reg[1]) + DDW'(dsq_reg[2]);
            dd4_reg <= dd3_reg;
            dd5_reg <= dd4_reg;
            dd6_reg <= dd5_reg;
            dd7_reg <= dd6_reg;
            if (dd3_reg == '0) begin
                st4_reg <= ST_ZERO_LINE;
            end else if (c_reg[0] == '0 && c_reg[1] == '0 && c_reg[2] == '0) begin
                st4_reg <= ST_ON_LINE;
            end else begin
                st4_reg <= ST_OK;
            end
            st5_reg <= st4_reg;
            st6_reg <= st5_reg;
            st7_reg <= st6_reg;
            cc_reg  <= CCW'(sq_reg[0]) + CCW'(sq_reg[1]) + CCW'(sq_reg[2]);
        end
    end

    // Distance: quotient of the squared lengths, then its square root.
    assign cc_hi = cc_reg[CCW-1:QW];
    assign ovf   = cc_hi >= (CCW-QW)'(dd7_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_pr_reg[0]  <= cc_reg[QW+DDW-1:QW];
            dv_lo_reg[0]  <= cc_reg[QW-1:0];
            dv_dd_reg[0]  <= dd7_reg;
            sd_dly_reg[0] <= {ovf, st7_reg};
            for (int j = 1; j < SD_DLY; j++) begin
                sd_dly_reg[j] <= sd_dly_reg[j-1];
            end
        end
    end

    for (genvar k = 1; k <= DDIV; k++) begin : g_ddiv
        logic [DDW:0] t;
        logic [DDW:0] diff;
        logic         take;

        assign t    = {dv_pr_reg[k-1], dv_lo_reg[k-1][QW-1]};
        assign diff = t - {1'b0, dv_dd_reg[k-1]};
        assign take = t >= {1'b0, dv_dd_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_pr_reg[k] <= take ? diff[DDW-1:0] : t[DDW-1:0];
                dv_lo_reg[k] <= {dv_lo_reg[k-1][QW-2:0], take};
                dv_dd_reg[k] <= dv_dd_reg[k-1];
            end
        end
    end

    ptld_isqrt u_dist_sqrt (
        .aclk     (aclk),
        .en       (en),
        .x_in     (dv_lo_reg[DDIV]),
        .root_out (d_root)
    );

    // Normal: bring the largest component under 31 bits, one shift amount per stage.
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int P = 1 << (NORM_STEPS - 1 - j);
        logic [NMW-1:0] any;
        logic           shift;

        assign any   = nz_reg[j][0] | nz_reg[j][1] | nz_reg[j][2];
        assign shift = |any[NMW-1:MW-1+P];

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    nz_reg[j+1][i] <= shift ? (nz_reg[j][i] >> P) : nz_reg[j][i];
                end
                nz_neg_reg[j+1] <= nz_neg_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                msq_reg[i]      <= nz_reg[NORM_STEPS][i][MW-1:0] * nz_reg[NORM_STEPS][i][MW-1:0];
                m_dly_reg[0][i] <= nz_reg[NORM_STEPS][i][MW-1:0];
            end
            neg_dly_reg[0] <= nz_neg_reg[NORM_STEPS];
            for (int j = 1; j < MN_DLY; j++) begin
                m_dly_reg[j]   <= m_dly_reg[j-1];
                neg_dly_reg[j] <= neg_dly_reg[j-1];
            end
            msum_reg <= SQ_W'(msq_reg[0]) + SQ_W'(msq_reg[1]) + SQ_W'(msq_reg[2]);
        end
    end

    ptld_isqrt u_len_sqrt (
        .aclk     (aclk),
        .en       (en),
        .x_in     (msum_reg),
        .root_out (n_len)
    );

    assign len_v = (n_len == '0) ? RT_W'(1) : n_len;

    for (genvar i = 0; i < 3; i++) begin : g_nprep
        logic [NUMW-1:0] num;

        assign num = (NUMW'(m_dly_reg[MN_DLY-1][i]) << ONE_SH) + NUMW'(len_v >> 1);

        always_ff @(posedge aclk) begin
            if (en) begin
                nd_pr_reg[0][i] <= RT_W'(num[NUMW-1:NQW]);
                nd_lo_reg[0][i] <= num[NQW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nd_len_reg[0] <= len_v;
            nd_neg_reg[0] <= neg_dly_reg[MN_DLY-1];
        end
    end

    for (genvar k = 1; k <= NQW; k++) begin : g_ndiv
        for (genvar i = 0; i < 3; i++) begin : g_ch
            logic [RT_W:0] t;
            logic [RT_W:0] diff;
            logic          take;

            assign t    = {nd_pr_reg[k-1][i], nd_lo_reg[k-1][i][NQW-1]};
            assign diff = t - {1'b0, nd_len_reg[k-1]};
            assign take = t >= {1'b0, nd_len_reg[k-1]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    nd_pr_reg[k][i] <= take ? diff[RT_W-1:0] : t[RT_W-1:0];
                    nd_lo_reg[k][i] <= {nd_lo_reg[k-1][i][NQW-2:0], take};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nd_len_reg[k] <= nd_len_reg[k-1];
                nd_neg_reg[k] <= nd_neg_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                nrm_dly_reg[0][i] <= nd_neg_reg[NQW][i] ? -$signed({1'b0, nd_lo_reg[NQW][i]})
                                                        : $signed({1'b0, nd_lo_reg[NQW][i]});
            end
            for (int j = 1; j < NRM_DLY; j++) begin
                nrm_dly_reg[j] <= nrm_dly_reg[j-1];
            end
        end
    end

    // A degenerate line or a point on the line gives zero distance and normal.
    assign fin_status = status_t'(sd_dly_reg[SD_DLY-1][ST_W-1:0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            status_reg <= fin_status;
            if (fin_status != ST_OK) begin
                dist_reg   <= '0;
                nx_reg     <= '0;
                ny_reg     <= '0;
                nz_out_reg <= '0;
            end else begin
                dist_reg   <= sd_dly_reg[SD_DLY-1][SD_W-1] ? '1 : d_root;
                nx_reg     <= nrm_dly_reg[NRM_DLY-1][0];
                ny_reg     <= nrm_dly_reg[NRM_DLY-1][1];
                nz_out_reg <= nrm_dly_reg[NRM_DLY-1][2];
            end
        end
    end

    assign m_valid    = vld_reg[LAT-1];
    assign m_distance = dist_reg;
    assign m_normal_x = nx_reg;
    assign m_normal_y = ny_reg;
    assign m_normal_z = nz_out_reg;
    assign m_status   = status_reg;

endmodule

>>> rtl/ptld_checker.sv
`timescale 1ns / 1ps
`include "point_to_line_distance_normal_top_macros.svh"

module ptld_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [ptld_pkg::DIST_W-1:0]           m_distance,
    input logic signed [ptld_pkg::NOUT_W-1:0]    m_normal_x,
    input logic signed [ptld_pkg::NOUT_W-1:0]    m_normal_y,
    input logic signed [ptld_pkg::NOUT_W-1:0]    m_normal_z,
    input logic [ptld_pkg::ST_W-1:0]             m_status
);
    import ptld_pkg::*;

    logic nrm_zero;
    logic nx_ok;
    logic ny_ok;
    logic nz_ok;

    assign nrm_zero = m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0;
    assign nx_ok    = m_normal_x <= 18'sd65536 && m_normal_x >= -18'sd65536;
    assign ny_ok    = m_normal_y <= 18'sd65536 && m_normal_y >= -18'sd65536;
    assign nz_ok    = m_normal_z <= 18'sd65536 && m_normal_z >= -18'sd65536;

    `PTLD_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")

    `PTLD_ASSERT(a_hold, m_valid && !m_ready |=> m_valid, "waiting item was dropped")

    `PTLD_ASSERT(a_degenerate_zero, m_valid && m_status != ST_OK |-> m_distance == '0 && nrm_zero, "degenerate item has nonzero output")

    `PTLD_ASSERT(a_normal_range, m_valid |-> nx_ok && ny_ok && nz_ok, "normal component out of range")

endmodule

bind point_to_line_distance_normal_top ptld_checker u_ptld_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ptld_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic [NOUT_W-1:0] nx;
        logic [NOUT_W-1:0] ny;
        logic [NOUT_W-1:0] nz;
        logic [ST_W-1:0]   status;
    } dist_res_t;

    typedef enum logic { ROW_LINE, ROW_QUERY } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [31:0] vals [6];
        logic        typed;
        dist_res_t   res;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 60;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_query_x = '0;
    logic signed [CW-1:0] s_query_y = '0;
    logic signed [CW-1:0] s_query_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DIST_W-1:0] m_distance;
    logic signed [NOUT_W-1:0] m_normal_x;
    logic signed [NOUT_W-1:0] m_normal_y;
    logic signed [NOUT_W-1:0] m_normal_z;
    logic [ST_W-1:0] m_status;
    logic cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_wdata = '0;

    logic [31:0] line_pt [6];
    dist_res_t expected_q [$];
    stim_row_t rows [$];
    int errors = 0;
    int cycles = 0;
    logic quiet = 1'b0;

    point_to_line_distance_normal_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_query_x(s_query_x), .s_query_y(s_query_y), .s_query_z(s_query_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_distance(m_distance), .m_normal_x(m_normal_x), .m_normal_y(m_normal_y),
        .m_normal_z(m_normal_z), .m_status(m_status),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic wide_t sx(logic [31:0] x);
        return {{224{x[31]}}, x};
    endfunction

    function automatic dist_res_t distance_to_line(logic [31:0] qx, logic [31:0] qy,
                                                   logic [31:0] qz);
        wide_t d [3];
        wide_t v [3];
        wide_t c [3];
        wide_t n [3];
        wide_t dd, cc, p;
        logic [31:0] q [3];
        logic [63:0] m [3];
        logic [63:0] sum, len, r, t, tt, val;
        logic [NOUT_W-1:0] nv [3];
        logic neg [3];
        int top, sh, i, b;
        dist_res_t res;
        q[0] = qx; q[1] = qy; q[2] = qz;
        for (i = 0; i < 3; i++) begin
            d[i] = sx(line_pt[3+i]) - sx(line_pt[i]);
            v[i] = sx(q[i]) - sx(line_pt[i]);
        end
        c[0] = d[1] * v[2] - d[2] * v[1];
        c[1] = d[2] * v[0] - d[0] * v[2];
        c[2] = d[0] * v[1] - d[1] * v[0];
        dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        cc = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
        res = '{default: '0};
        if (dd == 0) begin
            res.status = ST_ZERO_LINE;
            return res;
        end
        if (cc == 0) begin
            res.status = ST_ON_LINE;
            return res;
        end
        r = 0;
        for (b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            tt = t * t;
            p = {192'd0, tt} * dd;
            if ($unsigned(p) <= $unsigned(cc)) r = t;
        end
        res.distance = r[31:0];
        n[0] = c[1] * d[2] - c[2] * d[1];
        n[1] = c[2] * d[0] - c[0] * d[2];
        n[2] = c[0] * d[1] - c[1] * d[0];
        top = 0;
        for (i = 0; i < 3; i++) begin
            neg[i] = n[i][255];
            if (neg[i]) n[i] = -n[i];
            for (b = 255; b >= 0; b--) begin
                if (n[i][b]) begin
                    if (b + 1 > top) top = b + 1;
                    break;
                end
            end
        end
        sh = (top > 31) ? top - 31 : 0;
        sum = 0;
        for (i = 0; i < 3; i++) begin
            m[i] = 64'($unsigned(n[i]) >> sh);
            sum += m[i] * m[i];
        end
        len = 0;
        for (b = 31; b >= 0; b--) begin
            t = len | (64'd1 << b);
            if (t * t <= sum) len = t;
        end
        if (len == 0) len = 1;
        for (i = 0; i < 3; i++) begin
            val = ((m[i] << 16) + (len >> 1)) / len;
            if (neg[i]) val = -val;
            nv[i] = val[NOUT_W-1:0];
        end
        res.nx = nv[0];
        res.ny = nv[1];
        res.nz = nv[2];
        res.status = ST_OK;
        return res;
    endfunction

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LAT + 8) @(posedge aclk);
    endtask

    task automatic write_line(logic [31:0] pts [6]);
        int i;
        drain_pipeline();
        for (i = 0; i < 6; i++) begin
            cfg_wen <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_wdata <= pts[i];
            @(posedge aclk);
            line_pt[i] = pts[i];
        end
        cfg_wen <= 1'b0;
    endtask

    task automatic send_query(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz,
                              logic typed, dist_res_t typed_res);
        while (!quiet && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_query_x <= qx;
        s_query_y <= qy;
        s_query_z <= qz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(typed ? typed_res : distance_to_line(qx, qy, qz));
    endtask

    task automatic add_line(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d, logic [31:0] e, logic [31:0] f);
        stim_row_t row;
        row.kind = ROW_LINE;
        row.vals = '{a, b, c, d, e, f};
        row.typed = 1'b0;
        row.res = '{default: '0};
        rows.push_back(row);
    endtask

    task automatic add_query(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic typed, dist_res_t res);
        stim_row_t row;
        row.kind = ROW_QUERY;
        row.vals = '{a, b, c, 32'd0, 32'd0, 32'd0};
        row.typed = typed;
        row.res = res;
        rows.push_back(row);
    endtask

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(2 * 1048576) - 1048576;
            default: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** point_to_line_distance_normal_top: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        dist_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected item, distance %h status %0d",
                         $time, m_distance, m_status);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (m_distance !== want.distance) begin
                    $display("%0t: distance expected %h actual %h", $time,
                             want.distance, m_distance);
                    errors++;
                end
                if (m_normal_x !== want.nx) begin
                    $display("%0t: normal_x expected %h actual %h", $time, want.nx,
                             m_normal_x);
                    errors++;
                end
                if (m_normal_y !== want.ny) begin
                    $display("%0t: normal_y expected %h actual %h", $time, want.ny,
                             m_normal_y);
                    errors++;
                end
                if (m_normal_z !== want.nz) begin
                    $display("%0t: normal_z expected %h actual %h", $time, want.nz,
                             m_normal_z);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_status);
                    errors++;
                end
            end
        end
        m_ready <= quiet || ($urandom_range(99) >= 8);
    end

    initial begin
        dist_res_t zero_line, on_line, unit_y, none;
        logic [31:0] pts [6];
        logic [31:0] q [3];
        int ph, k, i, lmode, qpick;
        none = '{default: '0};
        zero_line = '{default: '0};
        zero_line.status = ST_ZERO_LINE;
        on_line = '{default: '0};
        on_line.status = ST_ON_LINE;
        unit_y = '{distance: 32'd65536, nx: '0, ny: 18'd65536, nz: '0, status: ST_OK};
        for (i = 0; i < 6; i++) line_pt[i] = '0;

        add_query(32'd65536, 32'd0, 32'd0, 1'b1, zero_line);
        add_query(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, zero_line);
        add_line(32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0);
        add_query(32'd0, 32'd65536, 32'd0, 1'b1, unit_y);
        add_query(32'd12345, 32'd0, 32'd0, 1'b1, on_line);
        add_query(32'hFFF0_0000, 32'd0, 32'd0, 1'b1, on_line);
        add_query(32'd7, 32'hFFFF_0000, 32'd3, 1'b0, none);
        add_query(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, none);
        add_line(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0001, 32'h8000_0000, 32'h8000_0000);
        add_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, none);
        add_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, none);
        add_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, on_line);
        add_line(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0, none);
        add_query(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, none);
        add_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, on_line);
        add_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none);
        add_line(32'h1234_5678, 32'hDEAD_0000, 32'h0000_0001,
                 32'h1234_5678, 32'hDEAD_0000, 32'h0000_0001);
        add_query(32'h1234_5678, 32'hDEAD_0000, 32'h0000_0001, 1'b1, zero_line);
        add_query(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b1, zero_line);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_LINE) write_line(rows[r].vals);
            else send_query(rows[r].vals[0], rows[r].vals[1], rows[r].vals[2],
                            rows[r].typed, rows[r].res);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            lmode = ph % 4;
            for (i = 0; i < 3; i++) begin
                pts[i] = pick_coord(lmode == 3 ? 0 : lmode);
                pts[3+i] = (lmode == 3) ? pts[i] : pick_coord(lmode == 3 ? 0 : lmode);
            end
            write_line(pts);
            quiet = (ph == 4);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                qpick = $urandom_range(99);
                for (i = 0; i < 3; i++) begin
                    if (qpick < 10) q[i] = line_pt[i];
                    else if (qpick < 15) q[i] = line_pt[3+i];
                    else if (qpick < 35) q[i] = line_pt[i] + $urandom_range(512) - 256;
                    else if (qpick < 50) q[i] = pick_coord(lmode == 3 ? 0 : lmode);
                    else q[i] = $urandom;
                end
                send_query(q[0], q[1], q[2], 1'b0, none);
            end
            quiet = 1'b0;
        end

        drain_pipeline();
        if (errors == 0) begin
            $display("** point_to_line_distance_normal_top: PASSED **");
        end else begin
            $display("** point_to_line_distance_normal_top: FAILED **");
        end
        $finish;
    end
endmodule

>>> point_to_line_distance_normal_top.f
+incdir+rtl
rtl/ptld_pkg.sv
rtl/ptld_isqrt.sv
rtl/point_to_line_distance_normal_top.sv
rtl/ptld_checker.sv
tb/sv/testbench.sv
